/* rtl/gdfs_pkg.sv */
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types, constants and the microcode table of the grid depth-first
// walker.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CELL_W   = ROW_W + COL_W;
  localparam int LEVEL_W  = $clog2(CELLS + 1);
  localparam int EPOCH_W  = 8;
  localparam int CFG_W    = 5;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [1:0] CFG_START_ROW = 2'd2;
  localparam logic [1:0] CFG_START_COL = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic       cell_open;
  } gdfs_req_t;

  typedef struct packed {
    logic       has_coord;
    logic [3:0] out_row;
    logic [3:0] out_col;
    logic       is_backtrack;
    logic       finished;
  } gdfs_res_t;

  // microprogram step addresses
  typedef logic [3:0] upc_t;
  localparam upc_t U_SWEEP      = 4'd0;
  localparam upc_t U_IDLE       = 4'd1;
  localparam upc_t U_WRITE      = 4'd2;
  localparam upc_t U_NOP        = 4'd3;
  localparam upc_t U_START      = 4'd4;
  localparam upc_t U_VSWEEP     = 4'd5;
  localparam upc_t U_START_PUSH = 4'd6;
  localparam upc_t U_STEP       = 4'd7;
  localparam upc_t U_SCAN       = 4'd8;
  localparam upc_t U_POP        = 4'd9;
  localparam upc_t U_POP_LOAD   = 4'd10;
  localparam upc_t U_PUSH       = 4'd11;

  typedef enum logic [3:0] {
    A_IDLE,
    A_SWEEP,
    A_VSWEEP,
    A_WRITE,
    A_EMIT_ZERO,
    A_NEW_EPOCH,
    A_START_PUSH,
    A_STEP_BEGIN,
    A_SCAN,
    A_POP,
    A_POP_LOAD,
    A_PUSH
  } action_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_DISPATCH,
    J_SWEEP_DONE,
    J_EPOCH_OK,
    J_EMPTY,
    J_HIT,
    J_LEVEL_ONE
  } jump_t;

  typedef enum logic [1:0] {
    H_NEVER,
    H_ALWAYS,
    H_SCAN_BUSY
  } hold_t;

  typedef struct packed {
    action_t act;
    jump_t   jmp;
    hold_t   hold;
    upc_t    target;
  } ucw_t;

  // Next step: jump if the condition holds, else stay if the hold
  // condition holds, else fall through.
  function automatic ucw_t ucode(upc_t upc);
    ucw_t w;
    case (upc)
      U_SWEEP:      w = '{A_SWEEP,      J_SWEEP_DONE, H_ALWAYS,    U_IDLE};
      U_IDLE:       w = '{A_IDLE,       J_DISPATCH,   H_ALWAYS,    U_IDLE};
      U_WRITE:      w = '{A_WRITE,      J_ALWAYS,     H_NEVER,     U_IDLE};
      U_NOP:        w = '{A_EMIT_ZERO,  J_ALWAYS,     H_NEVER,     U_IDLE};
      U_START:      w = '{A_NEW_EPOCH,  J_EPOCH_OK,   H_NEVER,     U_START_PUSH};
      U_VSWEEP:     w = '{A_VSWEEP,     J_SWEEP_DONE, H_ALWAYS,    U_START_PUSH};
      U_START_PUSH: w = '{A_START_PUSH, J_ALWAYS,     H_NEVER,     U_IDLE};
      U_STEP:       w = '{A_STEP_BEGIN, J_EMPTY,      H_NEVER,     U_IDLE};
      U_SCAN:       w = '{A_SCAN,       J_HIT,        H_SCAN_BUSY, U_PUSH};
      U_POP:        w = '{A_POP,        J_LEVEL_ONE,  H_NEVER,     U_IDLE};
      U_POP_LOAD:   w = '{A_POP_LOAD,   J_ALWAYS,     H_NEVER,     U_IDLE};
      U_PUSH:       w = '{A_PUSH,       J_ALWAYS,     H_NEVER,     U_IDLE};
      default:      w = '{A_IDLE,       J_ALWAYS,     H_NEVER,     U_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(logic [1:0] op);
    upc_t t;
    case (op)
      OP_WRITE: t = U_WRITE;
      OP_START: t = U_START;
      OP_STEP:  t = U_STEP;
      default:  t = U_NOP;
    endcase
    return t;
  endfunction

endpackage

/* rtl/grid_dfs_traversal.sv */
// ----------------------------------------------------------------------------
// grid_dfs_traversal
// Depth-first walk of a 4-connected grid, run by a microcoded sequencer over
// an open-cell RAM, a visited-tag RAM and a coordinate stack RAM.
// ----------------------------------------------------------------------------
// Sweep: every 255th start also runs a visited tag sweep before its push.
// Throughput: one request per result; the neighbour probe loop, one open and
//   one visited RAM read per neighbour, sets the step time.
// Reset: rst is synchronous; afterwards busy stays high while the open and
//   visited RAMs are swept clear. The receiver cannot stall.
// ----------------------------------------------------------------------------
module grid_dfs_traversal
  import gdfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  gdfs_req_t        request,
  output logic             busy,
  output logic             done,
  output gdfs_res_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(5);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(5);

  // sequencer
  upc_t upc;
  upc_t upc_next;
  upc_t jump_target;
  ucw_t ucw;
  logic jump;
  logic hold;

  // configuration
  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  logic [3:0]       start_row;
  logic [3:0]       start_col;
  logic [CFG_W-1:0] rows_use;
  logic [CFG_W-1:0] cols_use;

  // datapath
  gdfs_req_t           req_q;
  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  level_m2;
  logic [CELL_W-1:0]   cur;
  logic [EPOCH_W-1:0]  epoch;
  logic [CELL_W-1:0]   sweep_cnt;
  logic [2:0]          dir;
  logic                probe_valid;
  logic [1:0]          probe_dir;
  logic                probe_inb;
  logic [CELL_W-1:0]   probe_cell;

  logic [CFG_W-1:0]    cur_row;
  logic [CFG_W-1:0]    cur_col;
  logic [CFG_W-1:0]    nb_row;
  logic [CFG_W-1:0]    nb_col;
  logic                nb_edge;
  logic                nb_ok;
  logic [CELL_W-1:0]   nb_cell;
  logic [CELL_W-1:0]   start_cell;
  logic                start_ok;
  logic [CELL_W-1:0]   wr_cell;
  logic                wr_in_store;

  logic                full;
  logic                hit;
  logic                scan_end;
  logic                sweep_last;

  logic                emit;
  gdfs_res_t           res_next;

  // RAM ports
  logic                open_we;
  logic [CELL_W-1:0]   open_addr;
  logic                open_wdata;
  logic                open_rd;
  logic                vis_we;
  logic [CELL_W-1:0]   vis_addr;
  logic [EPOCH_W-1:0]  vis_wdata;
  logic [EPOCH_W-1:0]  vis_rd;
  logic                stk_we;
  logic [CELL_W-1:0]   stk_addr;
  logic [CELL_W-1:0]   stk_rd;

  assign ucw       = ucode(upc);
  assign busy      = (upc != U_IDLE);
  assign cfg_ready = 1'b1;

  assign rows_use = (grid_rows > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : grid_rows;
  assign cols_use = (grid_cols > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols;

  assign start_cell = {start_row[ROW_W-1:0], start_col[COL_W-1:0]};
  assign start_ok   = (CFG_W'(start_row) < rows_use) && (CFG_W'(start_col) < cols_use);
  assign wr_cell    = {req_q.cell_row[ROW_W-1:0], req_q.cell_col[COL_W-1:0]};
  assign wr_in_store = (int'(req_q.cell_row) < MAX_ROWS) && (int'(req_q.cell_col) < MAX_COLS);

  // neighbour of the top cell in the current probe direction
  always_comb begin
    cur_row = CFG_W'(cur[CELL_W-1:COL_W]);
    cur_col = CFG_W'(cur[COL_W-1:0]);
    nb_row  = cur_row;
    nb_col  = cur_col;
    nb_edge = 1'b0;
    case (dir[1:0])
      DIR_UP: begin
        nb_row  = cur_row - CFG_W'(1);
        nb_edge = (cur_row == '0);
      end
      DIR_LEFT: begin
        nb_col  = cur_col - CFG_W'(1);
        nb_edge = (cur_col == '0);
      end
      DIR_DOWN:  nb_row = cur_row + CFG_W'(1);
      DIR_RIGHT: nb_col = cur_col + CFG_W'(1);
      default:   nb_edge = 1'b1;
    endcase
    nb_ok   = !dir[2] && !nb_edge && (nb_row < rows_use) && (nb_col < cols_use);
    nb_cell = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
  end

  assign level_m2   = level - LEVEL_W'(2);
  assign full       = (level >= LEVEL_W'(CELLS));
  assign hit        = probe_valid && probe_inb && open_rd && (vis_rd != epoch) && !full;
  assign scan_end   = probe_valid && (probe_dir == DIR_RIGHT);
  assign sweep_last = (sweep_cnt == '1);

  // next step
  always_comb begin
    case (ucw.jmp)
      J_NEVER:      jump = 1'b0;
      J_ALWAYS:     jump = 1'b1;
      J_DISPATCH:   jump = start;
      J_SWEEP_DONE: jump = sweep_last;
      J_EPOCH_OK:   jump = (epoch != '1);
      J_EMPTY:      jump = (level == '0);
      J_HIT:        jump = hit;
      J_LEVEL_ONE:  jump = (level == LEVEL_W'(1));
      default:      jump = 1'b0;
    endcase
    case (ucw.hold)
      H_NEVER:     hold = 1'b0;
      H_ALWAYS:    hold = 1'b1;
      H_SCAN_BUSY: hold = !scan_end;
      default:     hold = 1'b0;
    endcase
    jump_target = (ucw.jmp == J_DISPATCH) ? dispatch(request.operation) : ucw.target;
    if (jump) begin
      upc_next = jump_target;
    end else if (hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  // RAM ports and result per action
  always_comb begin
    open_we    = 1'b0;
    open_addr  = nb_cell;
    open_wdata = 1'b0;
    vis_we     = 1'b0;
    vis_addr   = nb_cell;
    vis_wdata  = epoch;
    stk_we     = 1'b0;
    stk_addr   = level[CELL_W-1:0];
    emit       = 1'b0;
    res_next   = '0;
    case (ucw.act)
      A_SWEEP: begin
        open_we   = 1'b1;
        open_addr = sweep_cnt;
        vis_we    = 1'b1;
        vis_addr  = sweep_cnt;
        vis_wdata = '0;
      end
      A_VSWEEP: begin
        vis_we    = 1'b1;
        vis_addr  = sweep_cnt;
        vis_wdata = '0;
      end
      A_WRITE: begin
        open_we    = wr_in_store;
        open_addr  = wr_cell;
        open_wdata = req_q.cell_open;
        emit       = 1'b1;
      end
      A_EMIT_ZERO: emit = 1'b1;
      A_START_PUSH: begin
        vis_we            = start_ok;
        vis_addr          = start_cell;
        stk_we            = start_ok;
        stk_addr          = '0;
        emit              = 1'b1;
        res_next.finished = !start_ok;
      end
      A_STEP_BEGIN: begin
        emit              = (level == '0);
        res_next.finished = 1'b1;
      end
      A_POP: begin
        stk_addr          = level_m2[CELL_W-1:0];
        emit              = (level == LEVEL_W'(1));
        res_next.finished = 1'b1;
      end
      A_POP_LOAD: begin
        emit                  = 1'b1;
        res_next.has_coord    = 1'b1;
        res_next.out_row      = 4'(stk_rd[CELL_W-1:COL_W]);
        res_next.out_col      = 4'(stk_rd[COL_W-1:0]);
        res_next.is_backtrack = 1'b1;
      end
      A_PUSH: begin
        vis_we             = 1'b1;
        vis_addr           = probe_cell;
        stk_we             = 1'b1;
        emit               = 1'b1;
        res_next.has_coord = 1'b1;
        res_next.out_row   = 4'(probe_cell[CELL_W-1:COL_W]);
        res_next.out_col   = 4'(probe_cell[COL_W-1:0]);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upc         <= U_SWEEP;
      level       <= '0;
      cur         <= '0;
      epoch       <= EPOCH_W'(1);
      sweep_cnt   <= '0;
      dir         <= '0;
      probe_valid <= 1'b0;
      done        <= 1'b0;
      grid_rows   <= ROWS_RESET;
      grid_cols   <= COLS_RESET;
      start_row   <= '0;
      start_col   <= '0;
    end else begin
      upc  <= upc_next;
      done <= emit;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_GRID_ROWS: grid_rows <= cfg_data;
          CFG_GRID_COLS: grid_cols <= cfg_data;
          CFG_START_ROW: start_row <= cfg_data[3:0];
          CFG_START_COL: start_col <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (ucw.act)
        A_SWEEP: sweep_cnt <= sweep_cnt + CELL_W'(1);
        A_VSWEEP: begin
          sweep_cnt <= sweep_cnt + CELL_W'(1);
          // tags are all zero now, so restart the epoch count
          if (sweep_last) begin
            epoch <= EPOCH_W'(1);
          end
        end
        A_NEW_EPOCH: epoch <= epoch + EPOCH_W'(1);
        A_START_PUSH: begin
          if (start_ok) begin
            level <= LEVEL_W'(1);
            cur   <= start_cell;
          end else begin
            level <= '0;
          end
        end
        A_STEP_BEGIN: begin
          dir         <= '0;
          probe_valid <= 1'b0;
        end
        A_SCAN: begin
          dir         <= dir + 3'd1;
          probe_valid <= 1'b1;
        end
        A_POP:      level <= level - LEVEL_W'(1);
        A_POP_LOAD: cur   <= stk_rd;
        A_PUSH: begin
          level <= level + LEVEL_W'(1);
          cur   <= probe_cell;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= request;
    end
    if (emit) begin
      result <= res_next;
    end
    // hold the probed cell on a hit so the push sees it
    if (ucw.act == A_SCAN && !hit) begin
      probe_dir  <= dir[1:0];
      probe_inb  <= nb_ok;
      probe_cell <= nb_cell;
    end
  end

  gdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open_ram (
    .clk   (clk),
    .we    (open_we),
    .addr  (open_addr),
    .wdata (open_wdata),
    .rdata (open_rd)
  );

  gdfs_ram #(.WIDTH(EPOCH_W), .DEPTH(CELLS)) u_visit_ram (
    .clk   (clk),
    .we    (vis_we),
    .addr  (vis_addr),
    .wdata (vis_wdata),
    .rdata (vis_rd)
  );

  gdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata ((ucw.act == A_PUSH) ? probe_cell : start_cell),
    .rdata (stk_rd)
  );

endmodule

/* rtl/gdfs_ram.sv */
// ----------------------------------------------------------------------------
// gdfs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/gdfs_checker.sv */
// ----------------------------------------------------------------------------
// gdfs_checker
// Port-level checks of the grid walker, bound to the top level.
// ----------------------------------------------------------------------------
module gdfs_checker
  import gdfs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input gdfs_res_t result
);

  // two results never come back to back
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in the previous cycle");

  a_coord_not_finished: assert property (@(posedge clk) disable iff (rst)
    (done && result.has_coord) |-> !result.finished)
    else $error("coordinate result flagged finished");

  a_no_coord_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.has_coord) |->
      (result.out_row == '0 && result.out_col == '0 && !result.is_backtrack))
    else $error("result without coordinate carries cell data");

endmodule

bind grid_dfs_traversal gdfs_checker u_gdfs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* verif/tb_grid_dfs_traversal.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_dfs_traversal
// Self-checking bench for the grid depth-first walker: a scoreboard tracks the
// open map, visited marks and path stack, predicts one result per request and
// compares every strobed result field by field. Directed corner cases come
// first, then random walks, noise and a long run of restarts.
// ----------------------------------------------------------------------------
import gdfs_pkg::*;

class dfs_scoreboard;
  bit                open_cell [CELLS];
  bit                seen_cell [CELLS];
  logic [CELL_W-1:0] trail [CELLS];
  int                depth;
  logic [CELL_W-1:0] here;
  logic [CFG_W-1:0]  rows_cfg;
  logic [CFG_W-1:0]  cols_cfg;
  logic [3:0]        origin_row;
  logic [3:0]        origin_col;
  gdfs_res_t         awaited [$];
  int                errors;

  function new();
    foreach (open_cell[i]) begin
      open_cell[i] = 1'b0;
      seen_cell[i] = 1'b0;
    end
    depth      = 0;
    here       = '0;
    rows_cfg   = 5;
    cols_cfg   = 5;
    origin_row = '0;
    origin_col = '0;
    errors     = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void note_config(logic [1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_GRID_ROWS: rows_cfg   = data;
      CFG_GRID_COLS: cols_cfg   = data;
      CFG_START_ROW: origin_row = data[3:0];
      CFG_START_COL: origin_col = data[3:0];
      default: ;
    endcase
  endfunction

  function void note_request(gdfs_req_t req);
    gdfs_res_t         res;
    int                rows;
    int                cols;
    int                r;
    int                c;
    int                nr;
    int                nc;
    int                d;
    bit                moved;
    logic [CELL_W-1:0] nb;
    res  = '0;
    rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    cols = (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    case (req.operation)
      OP_WRITE: open_cell[{req.cell_row, req.cell_col}] = req.cell_open;
      OP_START: begin
        foreach (seen_cell[i]) seen_cell[i] = 1'b0;
        depth = 0;
        if (origin_row < rows && origin_col < cols) begin
          here            = {origin_row, origin_col};
          trail[0]        = here;
          depth           = 1;
          seen_cell[here] = 1'b1;
        end else begin
          res.finished = 1'b1;
        end
      end
      OP_STEP: begin
        if (depth == 0) begin
          res.finished = 1'b1;
        end else begin
          r     = here[CELL_W-1:COL_W];
          c     = here[COL_W-1:0];
          moved = 1'b0;
          // probe up, left, down, right; take the first free neighbor
          for (d = 0; d < 4 && !moved; d++) begin
            nr = r + ((d == 0) ? -1 : (d == 2) ? 1 : 0);
            nc = c + ((d == 1) ? -1 : (d == 3) ? 1 : 0);
            if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
              nb = {nr[3:0], nc[3:0]};
              if (open_cell[nb] && !seen_cell[nb] && depth < CELLS) begin
                trail[depth]  = nb;
                depth++;
                seen_cell[nb] = 1'b1;
                here          = nb;
                moved         = 1'b1;
                res.has_coord = 1'b1;
                res.out_row   = nb[CELL_W-1:COL_W];
                res.out_col   = nb[COL_W-1:0];
              end
            end
          end
          if (!moved) begin
            depth--;
            if (depth > 0) begin
              here             = trail[depth-1];
              res.has_coord    = 1'b1;
              res.out_row      = here[CELL_W-1:COL_W];
              res.out_col      = here[COL_W-1:0];
              res.is_backtrack = 1'b1;
            end else begin
              res.finished = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    awaited.insert(awaited.size(), res);
  endfunction

  function bit field_ok(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void check_result(gdfs_res_t got);
    gdfs_res_t want;
    bit        ok;
    if (awaited.size() == 0) begin
      $display("%0t: result with none pending, expected nothing, got %p", $time, got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    ok   = field_ok("has_coord", want.has_coord, got.has_coord);
    ok   = field_ok("out_row", want.out_row, got.out_row) && ok;
    ok   = field_ok("out_col", want.out_col, got.out_col) && ok;
    ok   = field_ok("is_backtrack", want.is_backtrack, got.is_backtrack) && ok;
    ok   = field_ok("finished", want.finished, got.finished) && ok;
    if (!ok) errors++;
  endfunction
endclass

module tb_grid_dfs_traversal;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 3000;

  logic             clk;
  logic             rst;
  logic             start;
  gdfs_req_t        request;
  logic             busy;
  logic             done;
  gdfs_res_t        result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dfs_scoreboard sb;
  int            items;
  int            stall_cycles;
  bit            gaps_on;
  bit            burst_done;

  grid_dfs_traversal i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results first, so a request taken on the same edge queues behind them
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_result(result);
      if (cfg_valid && cfg_ready === 1'b1) sb.note_config(cfg_index, cfg_data);
      if (start && busy === 1'b0) sb.note_request(request);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_grid_dfs_traversal NOT OK");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(17, 31);
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 16);
  endfunction

  task automatic send_request(input gdfs_req_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy !== 1'b0);
    items++;
  endtask

  task automatic issue(input logic [1:0] op);
    gdfs_req_t req;
    req           = gdfs_req_t'($urandom);
    req.operation = op;
    send_request(req);
  endtask

  task automatic write_cell(input int row, input int col, input bit open_bit);
    gdfs_req_t req;
    req.operation = OP_WRITE;
    req.cell_row  = row[3:0];
    req.cell_col  = col[3:0];
    req.cell_open = open_bit;
    send_request(req);
  endtask

  // drop start and hold until every pending result is back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_directed();
    gaps_on = 1'b1;
    issue(OP_STEP);
    issue(OP_UNUSED);
    write_cell(15, 15, 1'b1);
    write_cell(0, 0, 1'b0);
    // blocked origin still gets pushed, then pops straight to finished
    issue(OP_START);
    issue(OP_STEP);
    write_cell(0, 1, 1'b1);
    write_cell(1, 1, 1'b1);
    issue(OP_START);
    repeat (6) issue(OP_STEP);
    write_register(CFG_GRID_ROWS, 5'd0);
    issue(OP_START);
    issue(OP_STEP);
    // oversized counts saturate; start row carries a stray upper bit
    write_register(CFG_GRID_ROWS, 5'd31);
    write_register(CFG_GRID_COLS, 5'd31);
    write_register(CFG_START_ROW, 5'h1f);
    write_register(CFG_START_COL, 5'h0f);
    write_cell(15, 14, 1'b1);
    issue(OP_START);
    repeat (4) issue(OP_STEP);
  endtask

  task automatic walk_phase();
    int rows_v;
    int cols_v;
    int eff_r;
    int eff_c;
    int orow;
    int ocol;
    int writes;
    int steps;
    int r;
    int i;
    rows_v = pick_size();
    cols_v = pick_size();
    eff_r  = (rows_v > MAX_ROWS) ? MAX_ROWS : rows_v;
    eff_c  = (cols_v > MAX_COLS) ? MAX_COLS : cols_v;
    orow   = (eff_r > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, eff_r - 1)
                                                      : $urandom_range(0, 15);
    ocol   = (eff_c > 0 && $urandom_range(0, 9) != 0) ? $urandom_range(0, eff_c - 1)
                                                      : $urandom_range(0, 15);
    write_register(CFG_GRID_ROWS, rows_v[CFG_W-1:0]);
    write_register(CFG_GRID_COLS, cols_v[CFG_W-1:0]);
    write_register(CFG_START_ROW, {1'($urandom_range(0, 1)), orow[3:0]});
    write_register(CFG_START_COL, {1'($urandom_range(0, 1)), ocol[3:0]});
    gaps_on = ($urandom_range(0, 3) != 0);
    writes  = (eff_r * eff_c > 38) ? 40 : eff_r * eff_c + 2;
    for (i = 0; i < writes; i++) begin
      if (eff_r > 0 && eff_c > 0 && $urandom_range(0, 9) != 0) begin
        write_cell($urandom_range(0, eff_r - 1), $urandom_range(0, eff_c - 1),
                   $urandom_range(0, 9) < 7);
      end else begin
        write_cell($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom_range(0, 1)));
      end
    end
    write_cell(orow, ocol, $urandom_range(0, 7) != 0);
    issue(OP_START);
    steps = 2 * eff_r * eff_c + 3;
    if (steps > 60) steps = 60;
    for (i = 0; i < steps; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        write_cell($urandom_range(0, 15), $urandom_range(0, 15), 1'($urandom_range(0, 1)));
      end else if (r < 7) begin
        issue(OP_UNUSED);
      end else if (r < 9) begin
        issue(OP_START);
      end else begin
        issue(OP_STEP);
      end
    end
  endtask

  // long run of restarts so the visited marks roll over many walks
  task automatic restart_burst();
    int i;
    write_register(CFG_GRID_ROWS, 5'd6);
    write_register(CFG_GRID_COLS, 5'd6);
    write_register(CFG_START_ROW, 5'd2);
    write_register(CFG_START_COL, 5'd3);
    gaps_on = 1'b0;
    write_cell(2, 3, 1'b1);
    repeat (25) write_cell($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 3) != 0);
    for (i = 0; i < 260; i++) begin
      if (i == 130) gaps_on = 1'b1;
      issue(OP_START);
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) issue(OP_STEP);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    items        = 0;
    gaps_on      = 1'b0;
    burst_done   = 1'b0;
    sb           = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    while (items < 550) begin
      if (!burst_done && items >= 120) begin
        restart_burst();
        burst_done = 1'b1;
      end else begin
        walk_phase();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_grid_dfs_traversal OK");
    end else begin
      $display("tb_grid_dfs_traversal NOT OK");
    end
    $finish;
  end

endmodule

/* grid_dfs_traversal.f */
rtl/gdfs_pkg.sv
rtl/gdfs_ram.sv
rtl/grid_dfs_traversal.sv
rtl/gdfs_checker.sv
verif/tb_grid_dfs_traversal.sv
